[rtl/bcld_pkg.sv]
// Shared types, codes and constants for the button click / long-press detector.
// No dependencies; every other file imports this package.
package bcld_pkg;

    localparam int TIME_BITS = 32;
    localparam int MS_BITS   = 32;
    localparam int CMP_BITS  = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;
    localparam int CNT_BITS  = 8;
    localparam int EV_BITS   = 2;
    localparam int CFG_BITS  = 32;
    localparam int IDX_BITS  = 3;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [MS_BITS-1:0]   t_ms;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [CMP_BITS-1:0]  t_cmp;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_LONG     = 2'd2
    } t_mode;

    typedef enum logic [EV_BITS-1:0] {
        EV_PRESS   = 2'd0,
        EV_LONG    = 2'd1,
        EV_RELEASE = 2'd2
    } t_event;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_LONG_PRESS  = 3'd1,
        REG_CLICK_GAP   = 3'd2,
        REG_MAX_CLICKS  = 3'd3,
        REG_PRESS_LEVEL = 3'd4
    } t_reg_idx;

    localparam t_ms  RST_DEBOUNCE    = 32'd50;
    localparam t_ms  RST_LONG_PRESS  = 32'd1000;
    localparam t_ms  RST_CLICK_GAP   = 32'd400;
    localparam t_cnt RST_MAX_CLICKS  = 8'd3;
    localparam logic RST_PRESS_LEVEL = 1'b0;

    typedef struct packed {
        t_ms  debounce_ms;
        t_ms  long_press_ms;
        t_ms  click_gap_ms;
        t_cnt max_clicks;
        logic press_level;
    } t_cfg;

    typedef struct packed {
        logic pin_level;
        t_ms  now_ms;
    } t_poll;

    typedef struct packed {
        t_event event_res;
        t_cnt   click_tally;
    } t_result;

endpackage

[rtl/bcld_poll_if.sv]
// Valid/ready channel carrying one button poll word.
// Depends on bcld_pkg for field widths.
interface bcld_poll_if import bcld_pkg::*; ();
    logic valid;
    logic ready;
    logic pin_level;
    t_ms  now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

[rtl/bcld_event_if.sv]
// Valid/ready channel carrying one button event word.
// Depends on bcld_pkg for field widths.
interface bcld_event_if import bcld_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [EV_BITS-1:0]  event_res;
    t_cnt                click_tally;

    modport source (output valid, output event_res, output click_tally, input ready);
    modport sink   (input valid, input event_res, input click_tally, output ready);
endinterface

[rtl/bcld_cfg.sv]
// Configuration register bank for the button detector.
// Depends on bcld_pkg.
module bcld_cfg import bcld_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE:    n_cfg.debounce_ms   = i_cfg_wdata[MS_BITS-1:0];
                REG_LONG_PRESS:  n_cfg.long_press_ms = i_cfg_wdata[MS_BITS-1:0];
                REG_CLICK_GAP:   n_cfg.click_gap_ms  = i_cfg_wdata[MS_BITS-1:0];
                REG_MAX_CLICKS:  n_cfg.max_clicks    = i_cfg_wdata[CNT_BITS-1:0];
                REG_PRESS_LEVEL: n_cfg.press_level   = i_cfg_wdata[0];
                // drop writes beyond the register list
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= RST_DEBOUNCE;
            r_cfg.long_press_ms <= RST_LONG_PRESS;
            r_cfg.click_gap_ms  <= RST_CLICK_GAP;
            r_cfg.max_clicks    <= RST_MAX_CLICKS;
            r_cfg.press_level   <= RST_PRESS_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bcld_fsm.sv]
// Mode state machine, click counter and result register of the button detector.
// Works on the registered poll word; depends on bcld_pkg.
module bcld_fsm import bcld_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_poll_valid,
    input  t_poll   i_poll,
    output logic    o_take,
    input  logic    i_res_ready,
    output logic    o_res_valid,
    output t_result o_res
);

    t_mode   r_mode,  n_mode;
    t_time   r_mark,  n_mark;
    t_cnt    r_clicks, n_clicks;
    logic    r_res_valid, n_res_valid;
    t_result r_res,   n_res;

    t_time   now_t;
    t_cmp    elapsed;
    logic    pressed;
    logic    emit;
    t_result res;
    logic    take;

    assign take = i_poll_valid && (!r_res_valid || i_res_ready);

    always_comb begin
        now_t    = TIME_BITS'(i_poll.now_ms);
        elapsed  = CMP_BITS'(t_time'(now_t - r_mark));
        pressed  = (i_poll.pin_level == i_cfg.press_level);
        n_mode   = r_mode;
        n_mark   = r_mark;
        n_clicks = r_clicks;
        emit     = 1'b0;
        res      = '{event_res: EV_PRESS, click_tally: r_clicks};

        case (r_mode)
            MODE_PRESSED: begin
                if (pressed) begin
                    if (elapsed > CMP_BITS'(i_cfg.long_press_ms)) begin
                        emit   = 1'b1;
                        res    = '{event_res: EV_LONG, click_tally: '0};
                        n_mode = MODE_LONG;
                        n_mark = now_t;
                    end
                end else if (elapsed > CMP_BITS'(i_cfg.debounce_ms)) begin
                    emit   = 1'b1;
                    res    = '{event_res: EV_RELEASE, click_tally: r_clicks};
                    n_mode = MODE_RELEASED;
                    n_mark = now_t;
                end
            end
            MODE_LONG: begin
                // release from a long press skips the debounce
                if (!pressed) begin
                    emit     = 1'b1;
                    res      = '{event_res: EV_RELEASE, click_tally: r_clicks};
                    n_mode   = MODE_RELEASED;
                    n_mark   = now_t;
                    n_clicks = '0;
                end
            end
            default: begin
                // released, and the unused code behaves the same
                n_mode = MODE_RELEASED;
                if (pressed && elapsed > CMP_BITS'(i_cfg.debounce_ms)) begin
                    if (r_clicks < i_cfg.max_clicks) begin
                        n_clicks = r_clicks + 1'b1;
                    end
                    emit   = 1'b1;
                    res    = '{event_res: EV_PRESS, click_tally: n_clicks};
                    n_mode = MODE_PRESSED;
                    n_mark = now_t;
                end else if (elapsed > CMP_BITS'(i_cfg.click_gap_ms)) begin
                    n_clicks = '0;
                end
            end
        endcase

        if (!take) begin
            n_mode   = r_mode;
            n_mark   = r_mark;
            n_clicks = r_clicks;
        end

        // hold the result until taken, load a new one on an emitting step
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        if (take && emit) begin
            n_res_valid = 1'b1;
            n_res       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RELEASED;
            r_mark      <= '0;
            r_clicks    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_mark      <= n_mark;
            r_clicks    <= n_clicks;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_take      = take;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_long_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.event_res == EV_LONG) |-> (r_res.click_tally == '0))
        else $error("long press reported with a non-zero click count");

    a_long_from_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_mode != MODE_LONG) |=> (r_mode != MODE_LONG || $past(r_mode) == MODE_PRESSED))
        else $error("long-pressed mode entered from a mode other than pressed");

    a_state_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> ($stable(r_clicks) && $stable(r_mode) && $stable(r_mark)))
        else $error("state changed with no poll word consumed");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_mode == MODE_LONG && !pressed) |=> (r_clicks == '0 && r_res_valid))
        else $error("release from long press did not clear the count or report");

endmodule

[rtl/button_click_long_press_detector.sv]
// Button click / long-press detector: debounce, multi-click count, long press.
// A poll word is held in the input register, its event word in the result register.
// Throughput: one poll word per cycle while the event side takes each event word.
// A held event word stalls the input register, which then drops ready.
// Synchronous active-low reset: mode released, mark 0, count 0, registers to defaults.
module button_click_long_press_detector import bcld_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    bcld_poll_if.sink           i_poll,
    bcld_event_if.source        o_evt
);

    t_cfg    cfg;
    logic    take;
    logic    res_valid;
    t_result res;

    logic    r_in_valid, n_in_valid;
    t_poll   r_in,       n_in;

    bcld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register: refill when empty or when its word is consumed
    assign i_poll.ready = !r_in_valid || take;

    always_comb begin
        n_in_valid = r_in_valid && !take;
        n_in       = r_in;
        if (i_poll.valid && i_poll.ready) begin
            n_in_valid = 1'b1;
            n_in       = '{pin_level: i_poll.pin_level, now_ms: i_poll.now_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end

    bcld_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_poll_valid (r_in_valid),
        .i_poll       (r_in),
        .o_take       (take),
        .i_res_ready  (o_evt.ready),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign o_evt.valid       = res_valid;
    assign o_evt.event_res   = res.event_res;
    assign o_evt.click_tally = res.click_tally;

endmodule

[tb/tb_button_click_long_press_detector.sv]
// Self-checking testbench for the button click / long-press detector.
// Depends on bcld_pkg and the bcld_poll_if / bcld_event_if channels from the RTL.
// A local decoder predicts each event word; directed, random and back-pressure tests follow.
module tb_button_click_long_press_detector import bcld_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ERR_PRINT_MAX = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_BITS-1:0] i_cfg_wdata = '0;

    bcld_poll_if  poll_ch ();
    bcld_event_if event_ch ();

    button_click_long_press_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_poll      (poll_ch),
        .o_evt       (event_ch)
    );

    // Shadow of the detector state and registers
    t_cfg    cfg;
    t_mode   mode_q;
    t_time   mark_q;
    t_cnt    clicks_q;
    t_ms     last_now;
    t_result pending_events[$];

    int snd_idle_pct = 37;
    int rcv_idle_pct = 58;
    int err_count = 0;
    int stall_cycles = 0;

    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    initial begin
        poll_ch.valid     = 1'b0;
        poll_ch.pin_level = 1'b0;
        poll_ch.now_ms    = '0;
        event_ch.ready    = 1'b0;
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= ERR_PRINT_MAX) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    function automatic bit decode_poll(input logic pin, input t_ms now, output t_result res);
        bit    down;
        t_time now_t;
        t_time elapsed;
        down    = (pin == cfg.press_level);
        now_t   = t_time'(now);
        elapsed = now_t - mark_q;
        res     = '0;
        decode_poll = 1'b0;
        case (mode_q)
            MODE_PRESSED: begin
                if (down) begin
                    if (t_cmp'(elapsed) > t_cmp'(cfg.long_press_ms)) begin
                        res.event_res   = EV_LONG;
                        res.click_tally = '0;
                        mode_q = MODE_LONG;
                        mark_q = now_t;
                        decode_poll = 1'b1;
                    end
                end else if (t_cmp'(elapsed) > t_cmp'(cfg.debounce_ms)) begin
                    res.event_res   = EV_RELEASE;
                    res.click_tally = clicks_q;
                    mode_q = MODE_RELEASED;
                    mark_q = now_t;
                    decode_poll = 1'b1;
                end
            end
            MODE_LONG: begin
                // release is immediate here, and the count goes with it
                if (!down) begin
                    res.event_res   = EV_RELEASE;
                    res.click_tally = clicks_q;
                    mode_q   = MODE_RELEASED;
                    mark_q   = now_t;
                    clicks_q = '0;
                    decode_poll = 1'b1;
                end
            end
            default: begin
                mode_q = MODE_RELEASED;
                if (down && t_cmp'(elapsed) > t_cmp'(cfg.debounce_ms)) begin
                    if (clicks_q < cfg.max_clicks) clicks_q = clicks_q + 1'b1;
                    res.event_res   = EV_PRESS;
                    res.click_tally = clicks_q;
                    mode_q = MODE_PRESSED;
                    mark_q = now_t;
                    decode_poll = 1'b1;
                end else if (t_cmp'(elapsed) > t_cmp'(cfg.click_gap_ms)) begin
                    clicks_q = '0;
                end
            end
        endcase
    endfunction

    task automatic send_poll(input logic pin, input t_ms now);
        t_result res;
        // go idle cycle by cycle, each step drawn with the idle percentage as its chance
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            poll_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        poll_ch.valid     <= 1'b1;
        poll_ch.pin_level <= pin;
        poll_ch.now_ms    <= now;
        do @(posedge i_clk); while (!poll_ch.ready);
        if (decode_poll(pin, now, res)) pending_events.push_back(res);
        last_now = now;
    endtask

    // Let every expected word arrive, then the pipeline empty, before a register write
    task automatic drain_block();
        poll_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE:    cfg.debounce_ms   = data[MS_BITS-1:0];
            REG_LONG_PRESS:  cfg.long_press_ms = data[MS_BITS-1:0];
            REG_CLICK_GAP:   cfg.click_gap_ms  = data[MS_BITS-1:0];
            REG_MAX_CLICKS:  cfg.max_clicks    = data[CNT_BITS-1:0];
            REG_PRESS_LEVEL: cfg.press_level   = data[0];
            default: ;
        endcase
    endtask

    function automatic t_ms pick_threshold(input int unsigned scale);
        case ($urandom_range(0, 9))
            0:       pick_threshold = '0;
            1:       pick_threshold = '1;
            2:       pick_threshold = $urandom;
            default: pick_threshold = $urandom_range(1, scale);
        endcase
    endfunction

    // Default registers: strict thresholds, saturation, long press, gap clear, wrap
    task automatic test_default_thresholds();
        send_poll(1'b1, 32'd10);
        send_poll(1'b0, 32'd50);
        send_poll(1'b0, 32'd51);
        send_poll(1'b1, 32'd101);
        send_poll(1'b1, 32'd102);
        send_poll(1'b0, 32'd153);
        send_poll(1'b1, 32'd204);
        send_poll(1'b0, 32'd255);
        send_poll(1'b1, 32'd306);
        send_poll(1'b0, 32'd357);
        send_poll(1'b0, 32'd1357);
        send_poll(1'b0, 32'd1358);
        send_poll(1'b1, 32'd1358);
        send_poll(1'b0, 32'd1409);
        send_poll(1'b1, 32'd1460);
        send_poll(1'b1, 32'd1860);
        send_poll(1'b1, 32'd1861);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h0000_0040);
    endtask

    // Zero and full-scale registers, count above a lowered limit, unmapped indexes
    task automatic test_register_extremes();
        drain_block();
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_LONG_PRESS, '0);
        write_reg(REG_CLICK_GAP, '1);
        write_reg(REG_MAX_CLICKS, 32'd255);
        write_reg(REG_PRESS_LEVEL, 32'd1);
        send_poll(1'b1, 32'h41);
        send_poll(1'b1, 32'h42);
        send_poll(1'b1, 32'h43);
        send_poll(1'b0, 32'h43);
        send_poll(1'b1, 32'h44);
        send_poll(1'b0, 32'h45);
        drain_block();
        write_reg(REG_MAX_CLICKS, '0);
        for (int r = REG_PRESS_LEVEL + 1; r < (1 << IDX_BITS); r++)
            write_reg(IDX_BITS'(r), $urandom);
        send_poll(1'b1, 32'h46);
        send_poll(1'b0, 32'h47);
        drain_block();
        write_reg(REG_DEBOUNCE, '1);
        write_reg(REG_LONG_PRESS, '1);
        write_reg(REG_CLICK_GAP, '0);
        send_poll(1'b0, 32'h48);
        send_poll(1'b1, 32'h47);
    endtask

    // Mostly press/hold/release gestures timed around the thresholds, with bounce and jumps
    task automatic stream_button_activity(input int n_polls);
        bit   want_down;
        logic pin;
        t_ms  when;
        int   pick;
        want_down = 1'b0;
        for (int k = 0; k < n_polls; k++) begin
            if ($urandom_range(0, 99) < 25) want_down = ~want_down;
            pin = want_down ? cfg.press_level : ~cfg.press_level;
            if ($urandom_range(0, 99) < 8) pin = ~pin;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                when = last_now + t_ms'($urandom_range(0, 12));
            else if (pick < 55)
                when = mark_q + cfg.debounce_ms + t_ms'($urandom_range(0, 2)) - t_ms'(1);
            else if (pick < 70)
                when = mark_q + cfg.long_press_ms + t_ms'($urandom_range(0, 2)) - t_ms'(1);
            else if (pick < 80)
                when = mark_q + cfg.click_gap_ms + t_ms'($urandom_range(0, 2)) - t_ms'(1);
            else if (pick < 90)
                when = last_now;
            else
                when = $urandom;
            send_poll(pin, when);
        end
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_polls);
        logic [CFG_BITS-1:0] wdata;
        drain_block();
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        write_reg(REG_DEBOUNCE, pick_threshold(40));
        write_reg(REG_LONG_PRESS, pick_threshold(200));
        write_reg(REG_CLICK_GAP, pick_threshold(120));
        wdata = $urandom;
        case ($urandom_range(0, 5))
            0:       wdata[CNT_BITS-1:0] = '0;
            1:       wdata[CNT_BITS-1:0] = '1;
            2:       wdata[CNT_BITS-1:0] = CNT_BITS'($urandom);
            default: wdata[CNT_BITS-1:0] = CNT_BITS'($urandom_range(1, 6));
        endcase
        write_reg(REG_MAX_CLICKS, wdata);
        write_reg(REG_PRESS_LEVEL, $urandom);
        stream_button_activity(n_polls);
    endtask

    // Hold the event side off while every poll word raises an event, so input stalls
    task automatic test_receiver_hold_off();
        logic pin;
        drain_block();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_DEBOUNCE, 32'd5);
        write_reg(REG_LONG_PRESS, 32'd100);
        write_reg(REG_CLICK_GAP, 32'd50);
        write_reg(REG_MAX_CLICKS, 32'd255);
        write_reg(REG_PRESS_LEVEL, 32'd1);
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 40; k++) begin
            pin = (mode_q == MODE_RELEASED) ? cfg.press_level : ~cfg.press_level;
            send_poll(pin, mark_q + cfg.debounce_ms + t_ms'(1));
        end
    endtask

    task automatic check_event(input logic [EV_BITS-1:0] ev, input t_cnt cnt);
        t_result want;
        if (pending_events.size() == 0) begin
            flag_error($sformatf("event word with none pending: event %0d count %0d", ev, cnt));
        end else begin
            want = pending_events.pop_front();
            if (ev !== want.event_res)
                flag_error($sformatf("event_res %0d, want %0d", ev, want.event_res));
            if (cnt !== want.click_tally)
                flag_error($sformatf("click_tally %0d, want %0d", cnt, want.click_tally));
        end
    endtask

    // Event side: check each accepted word, drive ready, serve hold-off requests
    always @(posedge i_clk) begin
        if (event_ch.valid && event_ch.ready) check_event(event_ch.event_res, event_ch.click_tally);
        if (hold_toggle != hold_seen) begin
            hold_seen      <= hold_toggle;
            hold_left      <= HOLD_CYCLES;
            event_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            event_ch.ready <= 1'b0;
        end else begin
            event_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (poll_ch.valid && poll_ch.ready) || (event_ch.valid && event_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        cfg.debounce_ms   = RST_DEBOUNCE;
        cfg.long_press_ms = RST_LONG_PRESS;
        cfg.click_gap_ms  = RST_CLICK_GAP;
        cfg.max_clicks    = RST_MAX_CLICKS;
        cfg.press_level   = RST_PRESS_LEVEL;
        mode_q   = MODE_RELEASED;
        mark_q   = '0;
        clicks_q = '0;
        last_now = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_thresholds();
        test_register_extremes();
        test_random_traffic(37, 58, 190);
        test_random_traffic(37, 58, 190);
        test_random_traffic(58, 37, 190);
        test_random_traffic(58, 37, 190);
        test_receiver_hold_off();
        test_random_traffic(0, 0, 190);
        test_random_traffic(0, 0, 190);

        drain_block();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bcld_pkg.sv
rtl/bcld_poll_if.sv
rtl/bcld_event_if.sv
rtl/bcld_cfg.sv
rtl/bcld_fsm.sv
rtl/button_click_long_press_detector.sv
tb/tb_button_click_long_press_detector.sv
